[rtl/bre_pkg.sv]
`timescale 1ns / 1ps

package bre_pkg;

    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = 64;
    localparam int MAP_BITS   = WORD_BITS * MAP_WORDS;
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OPCODE_W   = 2;
    localparam int START_W    = 12;
    localparam int LENGTH_W   = 13;
    // Wide enough for the largest start plus the largest length.
    localparam int END_W      = 14;

    localparam logic [OPCODE_W-1:0] OP_TEST  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SET   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [START_W-1:0]  region_start;
        logic [LENGTH_W-1:0] region_length;
    } req_t;

    typedef struct packed {
        logic is_empty;
        logic out_of_range;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic start_scan;
        logic step;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic at_last;
    } sts_t;

endpackage

[rtl/bre_ram.sv]
`timescale 1ns / 1ps

module bre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/bre_ctrl.sv]
`timescale 1ns / 1ps

module bre_ctrl
    import bre_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    output logic   rsp_valid,
    input  logic   rsp_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.skip)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (sts.at_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_valid_next = cmd.load_out | (rsp_valid_reg & ~rsp_ready);
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/bre_dpath.sv]
`timescale 1ns / 1ps

module bre_dpath
    import bre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp
);

    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    logic [OPCODE_W-1:0]  op_reg;
    logic [START_W-1:0]   start_reg;
    logic [END_W-1:0]     end_reg;
    logic                 oor_reg;
    logic                 len0_reg;
    logic                 empty_reg, empty_next;
    logic [ADDR_W-1:0]    cur_reg, cur_next;
    logic [MAP_WORDS-1:0] valid_reg, valid_next;
    logic                 rd_valid_reg;
    rsp_t                 rsp_reg;

    logic [END_W-1:0]     req_end;
    logic [END_W-1:0]     end_m1;
    logic [ADDR_W-1:0]    first_word;
    logic [ADDR_W-1:0]    last_word;
    logic [BIT_IDX_W-1:0] lo_bit;
    logic [BIT_IDX_W-1:0] hi_bit;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] word_in;
    logic [WORD_BITS-1:0] word_out;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;

    assign req_end    = END_W'(req.region_start) + END_W'(req.region_length);
    assign end_m1     = end_reg - END_W'(1);
    assign first_word = ADDR_W'(start_reg >> BIT_IDX_W);
    assign last_word  = ADDR_W'(end_m1 >> BIT_IDX_W);

    // Edge masks apply only on the first and last words of the region.
    assign lo_bit = (cur_reg == first_word) ? start_reg[BIT_IDX_W-1:0] : '0;
    assign hi_bit = (cur_reg == last_word) ? end_m1[BIT_IDX_W-1:0]
                                           : BIT_IDX_W'(WORD_BITS - 1);
    assign mask   = (ONES << lo_bit) & (ONES >> (BIT_IDX_W'(WORD_BITS - 1) - hi_bit));

    assign word_in = rd_valid_reg ? rd_data : '0;

    always_comb
    begin
        word_out = word_in;
        unique case (op_reg)
            OP_CLEAR: word_out = word_in & ~mask;
            OP_SET:   word_out = word_in | mask;
            default:  word_out = word_in;
        endcase
    end

    assign wr_en   = cmd.step && (op_reg == OP_CLEAR || op_reg == OP_SET);
    // While scanning, fetch the word after the one being updated.
    assign rd_addr = cmd.start_scan ? first_word : cur_reg + ADDR_W'(1);

    bre_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (cur_reg),
        .wdata (word_out),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        empty_next = empty_reg;
        cur_next   = cur_reg;
        valid_next = valid_reg;
        if (cmd.load_req)
        begin
            empty_next = 1'b1;
        end
        if (cmd.start_scan)
        begin
            cur_next = first_word;
        end
        if (cmd.step)
        begin
            cur_next = cur_reg + ADDR_W'(1);
            if (op_reg == OP_TEST && (word_in & mask) != '0)
            begin
                empty_next = 1'b0;
            end
        end
        if (wr_en)
        begin
            valid_next[cur_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            empty_reg    <= 1'b1;
            cur_reg      <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
            empty_reg    <= empty_next;
            cur_reg      <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= req.opcode;
            start_reg <= req.region_start;
            end_reg   <= req_end;
            oor_reg   <= req_end > END_W'(MAP_BITS);
            len0_reg  <= req.region_length == '0;
        end
        if (cmd.load_out)
        begin
            rsp_reg.out_of_range <= oor_reg;
            rsp_reg.is_empty     <= !oor_reg && op_reg == OP_TEST && empty_reg;
        end
    end

    assign sts.skip    = oor_reg || len0_reg || op_reg == OP_NONE;
    assign sts.at_last = cur_reg == last_word;
    assign rsp         = rsp_reg;

endmodule

[rtl/bitmap_region_engine.sv]
// A request of n words (1 to 64) is checked, then scanned one map word per cycle, writing each
// back for set and clear; out-of-range, zero-length and no-op requests skip the scan. The result
// loads once the output register is free, raising rsp_valid; a new request waits for that load.
// Reset (rst_n, asynchronous, active low) empties the map at once through per-word valid bits.
`timescale 1ns / 1ps

module bitmap_region_engine
    import bre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    bre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bre_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a request is in progress");

    a_range_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.is_empty && rsp.out_of_range))
        else $error("out-of-range result reports an empty region");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(rsp_valid && !rsp_ready))
        else $error("result register overwritten before its transfer");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import bre_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int CALM_ITEMS    = 200;
    localparam int DRAIN_CYCLES  = 80;

    // Shadow copy of the allocation bitmap, kept one bit per map position.
    // Each accepted request is applied here in order, and its response is queued.
    class bitmap_shadow;
        logic [MAP_BITS-1:0] map_bits;
        rsp_t                expected_rsps[$];
        int                  failures;
        int                  checked;
        int                  n_tests;
        int                  n_found_empty;
        int                  n_sets;
        int                  n_clears;
        int                  n_out_of_range;

        function new();
            map_bits       = '0;
            failures       = 0;
            checked        = 0;
            n_tests        = 0;
            n_found_empty  = 0;
            n_sets         = 0;
            n_clears       = 0;
            n_out_of_range = 0;
        endfunction

        function void note_request(req_t r);
            int unsigned first;
            int unsigned stop;
            bit          all_zero;
            rsp_t        e;
            first    = r.region_start;
            stop     = first + r.region_length;
            all_zero = 1'b1;
            e        = '0;
            if (stop > MAP_BITS) begin
                e.out_of_range = 1'b1;
                n_out_of_range++;
            end else if (r.opcode != OP_NONE) begin
                for (int unsigned b = first; b < stop; b++) begin
                    case (r.opcode)
                        OP_TEST:  if (map_bits[b]) all_zero = 1'b0;
                        OP_CLEAR: map_bits[b] = 1'b0;
                        OP_SET:   map_bits[b] = 1'b1;
                        default:  ;
                    endcase
                end
                case (r.opcode)
                    OP_TEST:
                    begin
                        e.is_empty = all_zero;
                        n_tests++;
                        if (all_zero) n_found_empty++;
                    end
                    OP_CLEAR: n_clears++;
                    OP_SET:   n_sets++;
                    default:  ;
                endcase
            end
            expected_rsps.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (expected_rsps.size() == 0) begin
                $display("%0t: response with nothing expected: is_empty %0b out_of_range %0b",
                         $time, got.is_empty, got.out_of_range);
                failures++;
                return;
            end
            e = expected_rsps.pop_front();
            if (got.is_empty !== e.is_empty) begin
                $display("%0t: response %0d is_empty expected %0b actual %0b",
                         $time, checked, e.is_empty, got.is_empty);
                failures++;
            end
            if (got.out_of_range !== e.out_of_range) begin
                $display("%0t: response %0d out_of_range expected %0b actual %0b",
                         $time, checked, e.out_of_range, got.out_of_range);
                failures++;
            end
            checked++;
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         req_valid;
    logic         req_ready;
    req_t         req;
    logic         rsp_valid;
    logic         rsp_ready;
    rsp_t         rsp;

    bitmap_shadow sb;
    bit           calm;
    int unsigned  cycle_count;

    bitmap_region_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d responses outstanding.",
                     cycle_count, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    // Response side back-pressure: bursts of stall separated by calm stretches.
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        rsp_ready  = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (calm) begin
                stall_left = 0;
            end else if (stall_left == 0 && calm_left > 0) begin
                calm_left--;
            end else if (stall_left == 0 && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15);
                calm_left  = $urandom_range(0, 60);
            end
            if (stall_left > 0) begin
                rsp_ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic [OPCODE_W-1:0] op, input int unsigned start,
                                input int unsigned len);
        req_t r;
        r.opcode        = op;
        r.region_start  = START_W'(start);
        r.region_length = LENGTH_W'(len);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_random_request();
        logic [OPCODE_W-1:0] op;
        int unsigned         len;
        int                  start;
        int unsigned         pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)      op = OP_TEST;
        else if (pick < 62) op = OP_SET;
        else if (pick < 90) op = OP_CLEAR;
        else                op = OP_NONE;

        pick = $urandom_range(0, 99);
        if (pick < 55)      len = $urandom_range(0, 70);
        else if (pick < 80) len = $urandom_range(0, 300);
        else if (pick < 94) len = $urandom_range(0, MAP_BITS);
        else                len = $urandom_range(0, (1 << LENGTH_W) - 1);

        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            start = $urandom_range(0, MAP_BITS - 1);
        end else if (pick < 80) begin
            start = $urandom_range(0, MAP_WORDS - 1) * WORD_BITS;
        end else begin
            // Regions that end at or just around the top of the map.
            start = MAP_BITS - int'(len) + $urandom_range(0, 3) - 2;
            if (start < 0) start = 0;
            if (start > MAP_BITS - 1) start = MAP_BITS - 1;
        end
        send_request(op, start, len);
    endtask

    initial
    begin
        sb          = new();
        calm        = 1'b0;
        cycle_count = 0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: whole map, word edges, map end, zero length, unused opcode.
        send_request(OP_TEST,  0,    4096);
        send_request(OP_SET,   5,    1);
        send_request(OP_TEST,  6,    5);     // same word as the set bit, but outside it
        send_request(OP_TEST,  0,    6);
        send_request(OP_TEST,  0,    5);
        send_request(OP_SET,   4000, 96);    // ends exactly at the map end
        send_request(OP_TEST,  4095, 1);
        send_request(OP_TEST,  3999, 1);
        send_request(OP_TEST,  4095, 2);     // one bit past the end
        send_request(OP_SET,   1,    4096);
        send_request(OP_SET,   4095, 8191);
        send_request(OP_NONE,  0,    0);
        send_request(OP_NONE,  4095, 8191);
        send_request(OP_NONE,  100,  50);
        send_request(OP_TEST,  200,  0);
        send_request(OP_SET,   200,  0);
        send_request(OP_CLEAR, 200,  0);
        send_request(OP_SET,   60,   8);     // straddles a word boundary
        send_request(OP_CLEAR, 64,   4);
        send_request(OP_TEST,  64,   4);
        send_request(OP_TEST,  60,   4);
        send_request(OP_TEST,  128,  64);
        send_request(OP_SET,   0,    4096);
        send_request(OP_TEST,  2048, 1);
        send_request(OP_CLEAR, 0,    4096);
        send_request(OP_TEST,  0,    4096);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            send_random_request();
        end
        req_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d responses: %0d tests (%0d empty), %0d sets, %0d clears,",
                 sb.checked, sb.n_tests, sb.n_found_empty, sb.n_sets, sb.n_clears);
        $display("%0d out-of-range regions, with random stalls on both channels.",
                 sb.n_out_of_range);
        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
